[rtl/core/rss_pkg.sv]
package rss_pkg;

	localparam int NUM_GROUPS  = 6;
	localparam int NUM_CLASSES = 4;
	localparam int NUM_RECORDS = NUM_GROUPS * NUM_CLASSES;
	localparam int REC_ADDR_W  = $clog2(NUM_RECORDS);

	// first type group follows the three state groups
	localparam logic [2:0] GRP_TYPE_BASE = 3'd3;
	localparam logic [2:0] GRP_LIMIT     = 3'(NUM_GROUPS);
	localparam logic [1:0] CODE_NONE     = 2'd3;

	localparam logic [1:0] KIND_RECORD = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic REG_SMALL_LIMIT  = 1'b0;
	localparam logic REG_MEDIUM_LIMIT = 1'b1;

	localparam logic [31:0] SMALL_LIMIT_RST  = 32'd65536;
	localparam logic [31:0] MEDIUM_LIMIT_RST = 32'd1048576;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic                  clear;
		logic                  we;
		logic [REC_ADDR_W-1:0] waddr;
		logic [REC_ADDR_W-1:0] raddr;
	} store_cmd_t;

endpackage

[rtl/core/rss_record_store.sv]
module rss_record_store
	import rss_pkg::*;
#(
	parameter int SIZE_WIDTH  = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  store_cmd_t             cmd,
	input  logic [SIZE_WIDTH-1:0]  wr_min,
	input  logic [SIZE_WIDTH-1:0]  wr_max,
	input  logic [SIZE_WIDTH-1:0]  wr_total,
	input  logic [COUNT_WIDTH-1:0] wr_count,
	output logic [SIZE_WIDTH-1:0]  rd_min,
	output logic [SIZE_WIDTH-1:0]  rd_max,
	output logic [SIZE_WIDTH-1:0]  rd_total,
	output logic [COUNT_WIDTH-1:0] rd_count
);

	logic [SIZE_WIDTH-1:0]  min_q   [NUM_RECORDS];
	logic [SIZE_WIDTH-1:0]  max_q   [NUM_RECORDS];
	logic [SIZE_WIDTH-1:0]  total_q [NUM_RECORDS];
	logic [COUNT_WIDTH-1:0] count_q [NUM_RECORDS];
	logic [NUM_RECORDS-1:0] valid_q;

	// a record that is not valid reads as an empty record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
		end else if (cmd.we) begin
			valid_q[cmd.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			min_q[cmd.waddr]   <= wr_min;
			max_q[cmd.waddr]   <= wr_max;
			total_q[cmd.waddr] <= wr_total;
			count_q[cmd.waddr] <= wr_count;
		end
	end

	always_comb begin
		if (valid_q[cmd.raddr]) begin
			rd_min   = min_q[cmd.raddr];
			rd_max   = max_q[cmd.raddr];
			rd_total = total_q[cmd.raddr];
			rd_count = count_q[cmd.raddr];
		end else begin
			rd_min   = '1;
			rd_max   = '0;
			rd_total = '0;
			rd_count = '0;
		end
	end

endmodule

[rtl/core/rss_divider.sv]
module rss_divider
	import rss_pkg::*;
#(
	parameter int SIZE_WIDTH  = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SIZE_WIDTH-1:0]  dividend,
	input  logic [COUNT_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [SIZE_WIDTH-1:0]  quotient,
	output logic [COUNT_WIDTH-1:0] remainder
);

	localparam int STEP_W = $clog2(SIZE_WIDTH + 1);
	localparam logic [STEP_W-1:0] STEPS = STEP_W'(SIZE_WIDTH);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(1);

	logic                   busy_q;
	logic [STEP_W-1:0]      step_q;
	logic [SIZE_WIDTH-1:0]  quo_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] div_q;
	logic [COUNT_WIDTH:0]   trial;
	logic [COUNT_WIDTH:0]   diff;
	logic                   qbit;
	logic [COUNT_WIDTH-1:0] rem_next;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, quo_q[SIZE_WIDTH-1]};
		diff  = trial - {1'b0, div_q};
		qbit  = ~diff[COUNT_WIDTH];
		rem_next = qbit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
	end

	assign done      = busy_q && (step_q == LAST_STEP);
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEPS;
		end else if (busy_q) begin
			busy_q <= !done;
			step_q <= step_q - LAST_STEP;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SIZE_WIDTH-2:0], qbit};
			rem_q <= rem_next;
		end
	end

endmodule

[rtl/core/region_size_statistics_core.sv]
// record item: busy after the accept cycle, one record slot a cycle
// (state and type group, four classes each) through the shared update unit
// read item: result registered after the bit-serial divider when the count is
// nonzero, without it when the count is zero, and held back while
// out_stall holds the previous result; clear item: all records emptied
// reset: all records empty via per-record valid bits, limits 65536 and 1048576
module region_size_statistics_core
	import rss_pkg::*;
#(
	parameter int SIZE_WIDTH  = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] region_size,
	input  logic [1:0]  mem_state,
	input  logic [1:0]  mem_type,
	input  logic [2:0]  group_select,
	input  logic [1:0]  class_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] min_size,
	output logic [63:0] max_size,
	output logic [63:0] average_size,
	output logic [31:0] block_count,
	output logic [63:0] reported_total
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

	state_t state_q, state_d;

	logic [31:0]            small_limit_q;
	logic [31:0]            medium_limit_q;
	logic [SIZE_WIDTH-1:0]  size_q;
	logic [1:0]             mstate_q;
	logic [1:0]             mtype_q;
	logic [NUM_CLASSES-1:0] class_hit_q;
	logic [2:0]             slot_q;

	logic [SIZE_WIDTH-1:0]  rd_min_q;
	logic [SIZE_WIDTH-1:0]  rd_max_q;
	logic [SIZE_WIDTH-1:0]  rd_total_q;
	logic [COUNT_WIDTH-1:0] rd_count_q;

	logic                   out_valid_q;
	logic [63:0]            min_size_q;
	logic [63:0]            max_size_q;
	logic [63:0]            average_size_q;
	logic [31:0]            block_count_q;
	logic [63:0]            reported_total_q;

	store_cmd_t             st_cmd;
	logic [SIZE_WIDTH-1:0]  st_rd_min;
	logic [SIZE_WIDTH-1:0]  st_rd_max;
	logic [SIZE_WIDTH-1:0]  st_rd_total;
	logic [COUNT_WIDTH-1:0] st_rd_count;
	logic [SIZE_WIDTH-1:0]  wr_min;
	logic [SIZE_WIDTH-1:0]  wr_max;
	logic [SIZE_WIDTH-1:0]  wr_total;
	logic [COUNT_WIDTH-1:0] wr_count;
	logic [SIZE_WIDTH:0]    total_sum;

	logic                   div_start;
	logic                   div_done;
	logic [SIZE_WIDTH-1:0]  div_quo;
	logic [COUNT_WIDTH-1:0] div_rem;

	logic                   accept;
	logic                   read_ok;
	logic                   le_small;
	logic                   le_medium;
	logic [2:0]             slot_group;
	logic                   slot_en;
	logic                   out_free;
	logic                   out_load;
	logic                   rd_nonzero;
	logic [63:0]            count_ext;
	logic [SIZE_WIDTH-1:0]  size_in;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign size_in  = region_size[SIZE_WIDTH-1:0];
	assign read_ok  = (group_select < GRP_LIMIT);

	assign le_small  = 64'(size_in) <= 64'(small_limit_q);
	assign le_medium = 64'(size_in) <= 64'(medium_limit_q);

	// slot bit 2 picks the state or type group, bits 1:0 the class
	assign slot_group = slot_q[2] ? (GRP_TYPE_BASE + {1'b0, mtype_q}) : {1'b0, mstate_q};
	assign slot_en    = class_hit_q[slot_q[1:0]] &&
		(slot_q[2] ? (mtype_q != CODE_NONE) : (mstate_q != CODE_NONE));

	// shared update unit: saturating add and min/max compare on one record
	always_comb begin
		total_sum = {1'b0, st_rd_total} + {1'b0, size_q};
		wr_total  = total_sum[SIZE_WIDTH] ? '1 : total_sum[SIZE_WIDTH-1:0];
		wr_count  = (st_rd_count == COUNT_MAX) ? st_rd_count : st_rd_count + COUNT_ONE;
		wr_max    = (size_q > st_rd_max) ? size_q : st_rd_max;
		wr_min    = (size_q < st_rd_min) ? size_q : st_rd_min;
	end

	assign out_free   = !out_valid_q || !out_stall;
	assign rd_nonzero = (rd_count_q != '0);

	always_comb begin
		state_d      = state_q;
		st_cmd.clear = 1'b0;
		st_cmd.we    = 1'b0;
		st_cmd.waddr = {slot_group, slot_q[1:0]};
		st_cmd.raddr = {slot_group, slot_q[1:0]};
		div_start    = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				st_cmd.raddr = read_ok ? {group_select, class_select} : '0;
				if (accept) begin
					priority case (kind)
						KIND_RECORD: state_d = ST_UPDATE;
						KIND_CLEAR:  st_cmd.clear = 1'b1;
						KIND_READ: begin
							if (read_ok && (st_rd_count != '0)) begin
								div_start = 1'b1;
								state_d   = ST_DIVIDE;
							end else begin
								state_d = ST_RESULT;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_UPDATE: begin
				st_cmd.we = slot_en;
				if (slot_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_limit_q  <= SMALL_LIMIT_RST;
			medium_limit_q <= MEDIUM_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SMALL_LIMIT:  small_limit_q  <= cfg_data;
				REG_MEDIUM_LIMIT: medium_limit_q <= cfg_data;
				default:          small_limit_q  <= small_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			slot_q <= slot_q + 3'd1;
		end else begin
			slot_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q      <= size_in;
			mstate_q    <= mem_state;
			mtype_q     <= mem_type;
			class_hit_q <= {!le_medium, !le_small && le_medium, le_small, 1'b1};
			// unknown group reads back as an all-zero record
			rd_min_q    <= read_ok ? st_rd_min : '0;
			rd_max_q    <= read_ok ? st_rd_max : '0;
			rd_total_q  <= read_ok ? st_rd_total : '0;
			rd_count_q  <= read_ok ? st_rd_count : '0;
		end
	end

	assign count_ext = 64'(rd_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			min_size_q     <= rd_nonzero ? 64'(rd_min_q) : '0;
			max_size_q     <= 64'(rd_max_q);
			average_size_q <= rd_nonzero ? 64'(div_quo) : '0;
			block_count_q  <= count_ext[31:0];
			// count times average is the total less the remainder
			reported_total_q <= rd_nonzero ? (64'(rd_total_q) - 64'(div_rem)) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign min_size       = min_size_q;
	assign max_size       = max_size_q;
	assign average_size   = average_size_q;
	assign block_count    = block_count_q;
	assign reported_total = reported_total_q;

	rss_record_store #(
		.SIZE_WIDTH  (SIZE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (st_cmd),
		.wr_min   (wr_min),
		.wr_max   (wr_max),
		.wr_total (wr_total),
		.wr_count (wr_count),
		.rd_min   (st_rd_min),
		.rd_max   (st_rd_max),
		.rd_total (st_rd_total),
		.rd_count (st_rd_count)
	);

	rss_divider #(
		.SIZE_WIDTH  (SIZE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (st_rd_total),
		.divisor   (st_rd_count),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	a_div_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide state");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_RESULT))
		else $error("result shown without a read in progress");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_cmd.we |-> (st_cmd.waddr < REC_ADDR_W'(NUM_RECORDS)))
		else $error("record write beyond the last record");

	a_record_starts_update: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == KIND_RECORD)) |=> (state_q == ST_UPDATE) && (slot_q == 3'd0))
		else $error("record item did not start the update sweep");

	a_no_write_outside_update: assert property (@(posedge clk) disable iff (!arst_n)
		st_cmd.we |-> (state_q == ST_UPDATE) && !st_cmd.clear)
		else $error("record write outside the update sweep");

endmodule
